FILE: rtl/pssc_pkg.sv
// ----------------------------------------------------------------------------
// pssc_pkg - part sort station controller shared definitions
// Widths, command and class codes, register indexes and payload types.
// ----------------------------------------------------------------------------
package pssc_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_BITS  = 16;

   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CMD_W       = 2;
   localparam int SAMPLE_W    = 10;
   localparam int LIMIT_W     = 10;
   localparam int READING_W   = 11;
   localparam int CLASS_W     = 3;
   localparam int STEPS_W     = 7;
   localparam int CSR_INDEX_W = 3;

   // commands
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PASSED = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;

   // part classes, also turntable slots
   localparam logic [CLASS_W-1:0] CLS_NONE  = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_BLACK = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_STEEL = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_WHITE = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_ALUM  = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ALUMINUM_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEEL_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WHITE_LIMIT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BLACK_LIMIT    = 3'd3;

   localparam logic [LIMIT_W-1:0] ALUMINUM_LIMIT_RST = 10'd300;
   localparam logic [LIMIT_W-1:0] STEEL_LIMIT_RST    = 10'd750;
   localparam logic [LIMIT_W-1:0] WHITE_LIMIT_RST    = 10'd940;
   localparam logic [LIMIT_W-1:0] BLACK_LIMIT_RST    = 10'd1010;

   localparam logic [READING_W-1:0] START_READING = 11'd2000;
   localparam logic [STEPS_W-1:0]   QUARTER_STEPS = 7'd50;
   localparam logic [STEPS_W-1:0]   HALF_STEPS    = 7'd100;

   typedef struct packed {
      logic [STEPS_W-1:0] steps;
      logic               clockwise;
      logic               dir_update;   // quarter turn sets the remembered direction
      logic               dir_value;
   } move_plan_type;

   typedef struct packed {
      logic [CLASS_W-1:0]    part_class;
      logic [STEPS_W-1:0]    move_steps;
      logic                  move_clockwise;
      logic [LEVEL_W-1:0]    queue_level;
      logic [COUNT_BITS-1:0] aluminum_total;
      logic [COUNT_BITS-1:0] steel_total;
      logic [COUNT_BITS-1:0] white_total;
      logic [COUNT_BITS-1:0] black_total;
      logic [COUNT_BITS-1:0] classified_total;
      logic                  queue_overflow;
      logic                  queue_underflow;
   } rsp_payload_type;

endpackage

FILE: rtl/pssc_if.sv
// ----------------------------------------------------------------------------
// pssc_if - part sort station controller channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface pssc_req_if;
   logic                           valid;
   logic                           ready;
   logic [pssc_pkg::CMD_W-1:0]     cmd;
   logic [pssc_pkg::SAMPLE_W-1:0]  sample_value;

   modport source (output valid, output cmd, output sample_value, input ready);
   modport sink   (input valid, input cmd, input sample_value, output ready);
endinterface

interface pssc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pssc_pkg::CLASS_W-1:0]     part_class;
   logic [pssc_pkg::STEPS_W-1:0]     move_steps;
   logic                             move_clockwise;
   logic [pssc_pkg::LEVEL_W-1:0]     queue_level;
   logic [pssc_pkg::COUNT_BITS-1:0]  aluminum_total;
   logic [pssc_pkg::COUNT_BITS-1:0]  steel_total;
   logic [pssc_pkg::COUNT_BITS-1:0]  white_total;
   logic [pssc_pkg::COUNT_BITS-1:0]  black_total;
   logic [pssc_pkg::COUNT_BITS-1:0]  classified_total;
   logic                             queue_overflow;
   logic                             queue_underflow;

   modport source (output valid, output part_class, output move_steps,
                   output move_clockwise, output queue_level, output aluminum_total,
                   output steel_total, output white_total, output black_total,
                   output classified_total, output queue_overflow,
                   output queue_underflow, input ready);
   modport sink   (input valid, input part_class, input move_steps,
                   input move_clockwise, input queue_level, input aluminum_total,
                   input steel_total, input white_total, input black_total,
                   input classified_total, input queue_overflow,
                   input queue_underflow, output ready);
endinterface

interface pssc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pssc_pkg::CSR_INDEX_W-1:0]  index;
   logic [pssc_pkg::LIMIT_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pssc_move_plan.sv
// ----------------------------------------------------------------------------
// pssc_move_plan - turntable move selection
// Picks step count and direction from target slot versus current slot.
// ----------------------------------------------------------------------------
module pssc_move_plan (
   input  logic [pssc_pkg::CLASS_W-1:0] target,
   input  logic [pssc_pkg::CLASS_W-1:0] slot,
   input  logic                         last_dir,
   output pssc_pkg::move_plan_type      plan
);
   import pssc_pkg::*;

   localparam logic signed [CLASS_W:0] D_POS1 = 4'sd1;
   localparam logic signed [CLASS_W:0] D_POS2 = 4'sd2;
   localparam logic signed [CLASS_W:0] D_POS3 = 4'sd3;
   localparam logic signed [CLASS_W:0] D_NEG1 = -4'sd1;
   localparam logic signed [CLASS_W:0] D_NEG2 = -4'sd2;
   localparam logic signed [CLASS_W:0] D_NEG3 = -4'sd3;

   logic signed [CLASS_W:0] delta;

   assign delta = $signed({1'b0, target}) - $signed({1'b0, slot});

   always_comb begin
      plan = '0;
      if (delta == D_POS3 || delta == D_NEG1) begin
         plan.steps      = QUARTER_STEPS;
         plan.clockwise  = 1'b0;
         plan.dir_update = 1'b1;
         plan.dir_value  = 1'b0;
      end else if (delta == D_NEG3 || delta == D_POS1) begin
         plan.steps      = QUARTER_STEPS;
         plan.clockwise  = 1'b1;
         plan.dir_update = 1'b1;
         plan.dir_value  = 1'b1;
      end else if (delta == D_POS2 || delta == D_NEG2) begin
         plan.steps      = HALF_STEPS;
         plan.clockwise  = last_dir;
      end else begin
         plan.steps      = '0;
         plan.clockwise  = 1'b1;
      end
   end

endmodule

FILE: rtl/part_sort_station_controller_core.sv
// ----------------------------------------------------------------------------
// part_sort_station_controller_core - conveyor sorting controller
// Tracks the minimum reflectance, classifies parts, queues classes, counts
// sorted parts and orders turntable moves.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per transfer: a reflectance sample, a
//   "part left sensor" event or a "part at exit" event. Every request
//   transfer produces exactly one response transfer on rsp_chan with the
//   class, the ordered move, the queue level, all tallies and the
//   overflow/underflow flags.
//   csr_chan writes the four class limits; it is always ready, and writes
//   to indexes above the black limit are dropped. Write only while idle.
// Latency and throughput:
//   The response is valid the cycle after the request transfer. All work
//   (compare chain, queue push/pop, tally increment, move choice) sits
//   between the state registers and the response register, so one request
//   is taken every cycle unless a held response stalls req_chan.
// Reset:
//   Limits return to 300/750/940/1010, tallies and queue pointers clear,
//   the minimum returns to 2000, the table sits at the black slot facing
//   clockwise. Queue entries are not cleared; only written ones are read.
// Stall:
//   The response register holds while rsp_chan.ready is low; req_chan.ready
//   drops only when that register is full and not being drained.
// ----------------------------------------------------------------------------
module part_sort_station_controller_core (
   input  logic             clock,
   input  logic             reset,
   pssc_req_if.sink         req_chan,
   pssc_rsp_if.source       rsp_chan,
   pssc_csr_if.sink         csr_chan
);
   import pssc_pkg::*;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // configuration
   logic [LIMIT_W-1:0] alum_limit_ff, steel_limit_ff, white_limit_ff, black_limit_ff;

   // sorting state
   logic [READING_W-1:0]  lowest_ff, lowest_in;
   logic [CLASS_W-1:0]    fifo_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [LEVEL_W-1:0]    fill_ff, fill_in;
   logic [CLASS_W-1:0]    slot_ff, slot_in;
   logic                  last_dir_ff, last_dir_in;
   logic [COUNT_BITS-1:0] tally_alum_ff, tally_alum_in;
   logic [COUNT_BITS-1:0] tally_steel_ff, tally_steel_in;
   logic [COUNT_BITS-1:0] tally_white_ff, tally_white_in;
   logic [COUNT_BITS-1:0] tally_black_ff, tally_black_in;
   logic [COUNT_BITS-1:0] tally_class_ff, tally_class_in;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic               req_xfer;
   logic               csr_xfer;
   logic               push_en;
   logic [CLASS_W-1:0] found_class;
   logic [CLASS_W-1:0] head_class;
   logic [CLASS_W-1:0] routed_class;
   move_plan_type      plan;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_xfer       = csr_chan.valid;

   // threshold chain on the running minimum; first match wins
   always_comb begin
      if (lowest_ff <= {1'b0, alum_limit_ff}) begin
         found_class = CLS_ALUM;
      end else if (lowest_ff <= {1'b0, steel_limit_ff}) begin
         found_class = CLS_STEEL;
      end else if (lowest_ff <= {1'b0, white_limit_ff}) begin
         found_class = CLS_WHITE;
      end else if (lowest_ff <= {1'b0, black_limit_ff}) begin
         found_class = CLS_BLACK;
      end else begin
         found_class = CLS_NONE;
      end
   end

   // unclassified parts leave through the black bin
   assign head_class   = fifo_mem_ff[head_ff];
   assign routed_class = (head_class < CLS_BLACK || head_class > CLS_ALUM) ?
                         CLS_BLACK : head_class;

   pssc_move_plan u_move_plan (
      .target   (routed_class),
      .slot     (slot_ff),
      .last_dir (last_dir_ff),
      .plan     (plan)
   );

   always_comb begin
      lowest_in      = lowest_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      slot_in        = slot_ff;
      last_dir_in    = last_dir_ff;
      tally_alum_in  = tally_alum_ff;
      tally_steel_in = tally_steel_ff;
      tally_white_in = tally_white_ff;
      tally_black_in = tally_black_ff;
      tally_class_in = tally_class_ff;
      push_en        = 1'b0;
      rsp_in         = rsp_ff;

      if (req_xfer) begin
         rsp_in.part_class      = CLS_NONE;
         rsp_in.move_steps      = '0;
         rsp_in.move_clockwise  = 1'b0;
         rsp_in.queue_overflow  = 1'b0;
         rsp_in.queue_underflow = 1'b0;

         case (req_chan.cmd)
            CMD_SAMPLE: begin
               if ({1'b0, req_chan.sample_value} < lowest_ff) begin
                  lowest_in = {1'b0, req_chan.sample_value};
               end
            end
            CMD_PASSED: begin
               rsp_in.part_class = found_class;
               if (found_class != CLS_NONE) begin
                  tally_class_in = tally_class_ff + COUNT_BITS'(1);
               end
               if (fill_ff == LEVEL_W'(QUEUE_DEPTH)) begin
                  rsp_in.queue_overflow = 1'b1;
               end else begin
                  push_en = 1'b1;
                  tail_in = next_ptr(tail_ff);
                  fill_in = fill_ff + LEVEL_W'(1);
               end
               lowest_in = START_READING;
            end
            CMD_EXIT: begin
               if (fill_ff == '0) begin
                  rsp_in.queue_underflow = 1'b1;
               end else begin
                  head_in = next_ptr(head_ff);
                  fill_in = fill_ff - LEVEL_W'(1);
                  case (routed_class)
                     CLS_ALUM:  tally_alum_in  = tally_alum_ff + COUNT_BITS'(1);
                     CLS_STEEL: tally_steel_in = tally_steel_ff + COUNT_BITS'(1);
                     CLS_WHITE: tally_white_in = tally_white_ff + COUNT_BITS'(1);
                     default:   tally_black_in = tally_black_ff + COUNT_BITS'(1);
                  endcase
                  rsp_in.part_class     = routed_class;
                  rsp_in.move_steps     = plan.steps;
                  rsp_in.move_clockwise = plan.clockwise;
                  if (plan.dir_update) begin
                     last_dir_in = plan.dir_value;
                  end
                  slot_in = routed_class;
               end
            end
            default: begin
            end
         endcase

         rsp_in.queue_level      = fill_in;
         rsp_in.aluminum_total   = tally_alum_in;
         rsp_in.steel_total      = tally_steel_in;
         rsp_in.white_total      = tally_white_in;
         rsp_in.black_total      = tally_black_in;
         rsp_in.classified_total = tally_class_in;
      end

      // a new result replaces one being drained in the same cycle
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alum_limit_ff  <= ALUMINUM_LIMIT_RST;
         steel_limit_ff <= STEEL_LIMIT_RST;
         white_limit_ff <= WHITE_LIMIT_RST;
         black_limit_ff <= BLACK_LIMIT_RST;
      end else if (csr_xfer) begin
         case (csr_chan.index)
            REG_ALUMINUM_LIMIT: alum_limit_ff  <= csr_chan.data;
            REG_STEEL_LIMIT:    steel_limit_ff <= csr_chan.data;
            REG_WHITE_LIMIT:    white_limit_ff <= csr_chan.data;
            REG_BLACK_LIMIT:    black_limit_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff      <= START_READING;
         head_ff        <= '0;
         tail_ff        <= '0;
         fill_ff        <= '0;
         slot_ff        <= CLS_BLACK;
         last_dir_ff    <= 1'b1;
         tally_alum_ff  <= '0;
         tally_steel_ff <= '0;
         tally_white_ff <= '0;
         tally_black_ff <= '0;
         tally_class_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         lowest_ff      <= lowest_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         fill_ff        <= fill_in;
         slot_ff        <= slot_in;
         last_dir_ff    <= last_dir_in;
         tally_alum_ff  <= tally_alum_in;
         tally_steel_ff <= tally_steel_in;
         tally_white_ff <= tally_white_in;
         tally_black_ff <= tally_black_in;
         tally_class_ff <= tally_class_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // queue storage and response payload carry no reset
   always_ff @(posedge clock) begin
      if (push_en) begin
         fifo_mem_ff[tail_ff] <= found_class;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.part_class       = rsp_ff.part_class;
   assign rsp_chan.move_steps       = rsp_ff.move_steps;
   assign rsp_chan.move_clockwise   = rsp_ff.move_clockwise;
   assign rsp_chan.queue_level      = rsp_ff.queue_level;
   assign rsp_chan.aluminum_total   = rsp_ff.aluminum_total;
   assign rsp_chan.steel_total      = rsp_ff.steel_total;
   assign rsp_chan.white_total      = rsp_ff.white_total;
   assign rsp_chan.black_total      = rsp_ff.black_total;
   assign rsp_chan.classified_total = rsp_ff.classified_total;
   assign rsp_chan.queue_overflow   = rsp_ff.queue_overflow;
   assign rsp_chan.queue_underflow  = rsp_ff.queue_underflow;

endmodule
